>>> rtl/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

    // strings of this many bytes or more are rejected
    localparam int unsigned ADDR_MAX = 128;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [16:0] PORT_SAT = 17'd65536;
    localparam logic [7:0]  HOST_CAP_RESET = 8'd64;

    typedef enum logic [3:0] {
        PP_SKIP   = 4'b0001,
        PP_SIGN   = 4'b0010,
        PP_DIGITS = 4'b0100,
        PP_FAIL   = 4'b1000
    } t_port_phase;

    typedef enum logic [2:0] {
        CP_NONE = 3'b001,
        CP_SEEN = 3'b010,
        CP_PORT = 3'b100
    } t_close_phase;

    typedef struct packed {
        t_port_phase phase;
        logic [16:0] acc;
    } t_port_state;

endpackage

>>> rtl/hps_port_step.sv
`timescale 1ns / 1ps

// One character of decimal port text: whitespace skip, optional '+', digits.
module hps_port_step
    import hps_pkg::*;
(
    input  t_port_state i_cur,
    input  logic [7:0]  i_byte,
    output t_port_state o_nxt
);

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [20:0] times_ten;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_space  = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign digit     = i_byte[3:0];
    // acc * 8 + acc * 2 + digit
    assign times_ten = {1'b0, i_cur.acc, 3'b000} + {3'b000, i_cur.acc, 1'b0}
                     + {17'd0, digit};

    always_comb begin
        o_nxt = i_cur;
        unique case (i_cur.phase)
            PP_SKIP: begin
                if (is_space) begin
                    o_nxt.phase = PP_SKIP;
                end else if (i_byte == CH_PLUS) begin
                    o_nxt.phase = PP_SIGN;
                end else if (is_digit) begin
                    o_nxt.phase = PP_DIGITS;
                    o_nxt.acc   = {13'd0, digit};
                end else begin
                    o_nxt.phase = PP_FAIL;
                end
            end
            PP_SIGN: begin
                if (is_digit) begin
                    o_nxt.phase = PP_DIGITS;
                    o_nxt.acc   = {13'd0, digit};
                end else begin
                    o_nxt.phase = PP_FAIL;
                end
            end
            PP_DIGITS: begin
                if (is_digit) begin
                    o_nxt.acc = (times_ten > {4'd0, PORT_SAT}) ? PORT_SAT : times_ten[16:0];
                end else begin
                    o_nxt.phase = PP_FAIL;
                end
            end
            PP_FAIL: begin
                o_nxt = i_cur;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

>>> rtl/host_port_splitter.sv
`timescale 1ns / 1ps
// The result word appears on o_m_tvalid in the cycle after the zero byte is taken.
// Throughput: one character word per cycle; a waiting result stalls input only while
// the single output register is full and i_m_tready is low.
// Reset (i_rst_n low, synchronous): parse state and output valid cleared,
// host_capacity back to 64.
module host_port_splitter
    import hps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: host_capacity
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [0] status, [1] host_offset, [8:2] host_length,
                                     // [24:9] port_number, [31:25] zero
);

    logic [7:0]   r_host_cap;
    logic [7:0]   r_byte_count, n_byte_count;
    logic         r_bracket, n_bracket;
    t_close_phase r_close_phase, n_close_phase;
    logic [7:0]   r_close_pos, n_close_pos;
    logic [1:0]   r_colon_cnt, n_colon_cnt;
    logic [7:0]   r_colon_pos, n_colon_pos;
    t_port_state  r_port, n_port;
    logic         r_error, n_error;
    logic         r_out_valid;
    logic [31:0]  r_out_data;

    logic         accept;
    logic         is_term;
    t_port_state  port_stepped;

    logic         ok;
    logic         has_port;
    logic         offset;
    logic [7:0]   hlen;
    logic [15:0]  port;
    logic [31:0]  result;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign accept  = i_s_tvalid && o_s_tready;
    assign is_term = (i_s_tdata == 8'd0);

    hps_port_step u_port_step (
        .i_cur  (r_port),
        .i_byte (i_s_tdata),
        .o_nxt  (port_stepped)
    );

    // running state for a non-zero byte
    always_comb begin
        n_byte_count  = r_byte_count;
        n_bracket     = r_bracket;
        n_close_phase = r_close_phase;
        n_close_pos   = r_close_pos;
        n_colon_cnt   = r_colon_cnt;
        n_colon_pos   = r_colon_pos;
        n_port        = r_port;
        n_error       = r_error;

        if ((r_byte_count == 8'd0) && (i_s_tdata == CH_OPEN)) begin
            n_bracket = 1'b1;
        end else if (r_bracket) begin
            unique case (r_close_phase)
                CP_NONE: begin
                    if (i_s_tdata == CH_CLOSE) begin
                        n_close_phase = CP_SEEN;
                        n_close_pos   = r_byte_count;
                    end
                end
                CP_SEEN: begin
                    if (i_s_tdata == CH_COLON) begin
                        n_close_phase = CP_PORT;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                CP_PORT: begin
                    n_port = port_stepped;
                end
                default: begin
                    n_close_phase = r_close_phase;
                end
            endcase
        end else begin
            if (r_colon_cnt != 2'd0) begin
                n_port = port_stepped;
            end
            if (i_s_tdata == CH_COLON) begin
                if (r_colon_cnt == 2'd0) begin
                    n_colon_pos = r_byte_count;
                end
                if (r_colon_cnt < 2'd2) begin
                    n_colon_cnt = r_colon_cnt + 2'd1;
                end
            end
        end

        if (r_byte_count != 8'hFF) begin
            n_byte_count = r_byte_count + 8'd1;
        end
    end

    // verdict on the terminating byte
    always_comb begin
        ok       = (r_byte_count != 8'd0) && (r_byte_count < 8'(ADDR_MAX));
        has_port = 1'b0;
        offset   = 1'b0;
        hlen     = r_byte_count;
        port     = 16'd0;

        if (r_bracket) begin
            offset = 1'b1;
            if ((r_close_phase == CP_NONE) || (r_close_pos <= 8'd1) || r_error) begin
                ok   = 1'b0;
                hlen = 8'd0;
            end else begin
                hlen     = r_close_pos - 8'd1;
                has_port = (r_close_phase == CP_PORT);
            end
        end else if (r_colon_cnt == 2'd1) begin
            hlen     = r_colon_pos;
            has_port = 1'b1;
        end

        if ((hlen == 8'd0) || (hlen >= r_host_cap)) begin
            ok = 1'b0;
        end

        if (has_port) begin
            if ((r_port.phase != PP_DIGITS) || (r_port.acc == 17'd0) || r_port.acc[16]) begin
                ok = 1'b0;
            end else begin
                port = r_port.acc[15:0];
            end
        end

        if (ok) begin
            result = {7'd0, port, hlen[6:0], offset, 1'b0};
        end else begin
            result = {31'd0, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_cap    <= HOST_CAP_RESET;
            r_byte_count  <= 8'd0;
            r_bracket     <= 1'b0;
            r_close_phase <= CP_NONE;
            r_close_pos   <= 8'd0;
            r_colon_cnt   <= 2'd0;
            r_colon_pos   <= 8'd0;
            r_port        <= '{phase: PP_SKIP, acc: 17'd0};
            r_error       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_host_cap <= i_cfg_data;
            end

            if (accept && is_term) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                if (is_term) begin
                    r_byte_count  <= 8'd0;
                    r_bracket     <= 1'b0;
                    r_close_phase <= CP_NONE;
                    r_close_pos   <= 8'd0;
                    r_colon_cnt   <= 2'd0;
                    r_colon_pos   <= 8'd0;
                    r_port        <= '{phase: PP_SKIP, acc: 17'd0};
                    r_error       <= 1'b0;
                end else begin
                    r_byte_count  <= n_byte_count;
                    r_bracket     <= n_bracket;
                    r_close_phase <= n_close_phase;
                    r_close_pos   <= n_close_pos;
                    r_colon_cnt   <= n_colon_cnt;
                    r_colon_pos   <= n_colon_pos;
                    r_port        <= n_port;
                    r_error       <= n_error;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_term) begin
            r_out_data <= result;
        end
    end

endmodule
